### hdl/assert_macros.svh
// Assertion macros used by the double-ended queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, off while i_rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/deque_pkg.sv
// Types, widths and codes of the double-ended queue.
package deque_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK       = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE  = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_RESP = 3'b100
    } t_state;

endpackage

### hdl/deque_ram.sv
// Simple dual-read RAM: one write port, two registered read ports.
module deque_ram #(
    parameter int DATA_W  = 32,
    parameter int DEPTH_N = 16,
    parameter int ADDR_W  = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH_N];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### hdl/double_ended_queue_top.sv
// Double-ended queue top level: ring buffer in RAM plus head/count control.
// An accepted item updates head and count, then front and back are read from
// the registered RAM, then the result register loads once the output is free.
// One item in flight: a new item is taken only after the last result is loaded,
// since front and back are read from the registered RAM after each pointer update.
// Reset (i_rst_n low, synchronous): queue empty, head at 0, no result pending.
// RAM contents are not cleared; only entries written by a push ever reach the result.
module double_ended_queue_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [deque_pkg::OP_W-1:0]           i_op,
    input  logic signed [deque_pkg::DATA_W-1:0]  i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [deque_pkg::STATUS_W-1:0]       o_status,
    output logic signed [deque_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [deque_pkg::DATA_W-1:0]  o_back_value,
    output logic [deque_pkg::CNT_W-1:0]          o_count
);

    import deque_pkg::*;
    `include "assert_macros.svh"

    localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // (base + off) mod DEPTH; base < DEPTH and off <= DEPTH, so one
    // conditional subtract is enough.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[IDX_W-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    t_status           r_status, n_status;

    logic              accept;
    logic              load_out;
    logic              q_full;
    logic              q_empty;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  head_dec;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [CNT_W-1:0]  back_off;
    logic [IDX_W-1:0]  back_addr;
    logic [DATA_W-1:0] rd_front;
    logic [DATA_W-1:0] rd_back;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_front;
    logic [DATA_W-1:0] r_out_back;
    logic [CNT_W-1:0]  r_out_count;

    // One item in flight: take a new one only once the last result is loaded.
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign load_out   = (r_state == ST_RESP) && (!r_out_valid || i_out_ready);

    assign q_full   = (r_count == DEPTH_C);
    assign q_empty  = (r_count == '0);
    assign head_inc = (r_head == LAST_IDX) ? '0 : IDX_W'(r_head + 1'b1);
    assign head_dec = (r_head == '0) ? LAST_IDX : IDX_W'(r_head - 1'b1);

    // Pointer and count update plus the single RAM write of a push.
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = ring_add(r_head, r_count);
        if (accept) begin
            n_status = STS_DONE;
            case (i_op)
                OP_PUSH_BACK: begin
                    if (q_full) begin
                        n_status = STS_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = CNT_W'(r_count + 1'b1);
                    end
                end
                OP_PUSH_FRONT: begin
                    if (q_full) begin
                        n_status = STS_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        n_head  = head_dec;
                        n_count = CNT_W'(r_count + 1'b1);
                    end
                end
                OP_POP_FRONT: begin
                    if (q_empty) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_head  = head_inc;
                        n_count = CNT_W'(r_count - 1'b1);
                    end
                end
                OP_POP_BACK: begin
                    if (q_empty) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_count = CNT_W'(r_count - 1'b1);
                    end
                end
                default: begin
                    // peek and unused codes: no change
                end
            endcase
            // realign the ring whenever it drains
            if (n_count == '0) begin
                n_head = '0;
            end
        end
    end

    // Read front and back with the updated pointers, the cycle after the write.
    assign rd_en     = (r_state == ST_READ);
    assign back_off  = q_empty ? '0 : CNT_W'(r_count - 1'b1);
    assign back_addr = ring_add(r_head, back_off);

    deque_ram #(
        .DATA_W  (DATA_W),
        .DEPTH_N (DEPTH),
        .ADDR_W  (IDX_W)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_push_value),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (r_head),
        .i_rd_addr_b (back_addr),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_back)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_status    <= STS_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_status <= n_status;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register; empty queue reports zero values.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_front  <= q_empty ? '0 : rd_front;
            r_out_back   <= q_empty ? '0 : rd_back;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;
    assign o_count       = r_out_count;

    `ASSERT_CLK(a_count_bound, (r_count <= DEPTH_C), "item count above depth")
    `ASSERT_CLK(a_empty_head, (r_count == '0) |-> (r_head == '0), "head not realigned")
    `ASSERT_CLK(a_accept_read, accept |=> (r_state == ST_READ), "accept did not start read")
    `ASSERT_CLK(a_full_status, (o_out_valid && (o_status == STS_FULL)) |-> (o_count == DEPTH_C), "full status with room left")
    `ASSERT_ALWAYS(a_empty_status, (o_out_valid && (o_status == STS_EMPTY)) |-> (o_count == '0), "empty status with items held")

endmodule
